FILE: sv/btmx_pkg.sv
package btmx_pkg;

	localparam int KEY_BITS   = 30;
	localparam int NODE_COUNT = 8192;
	localparam int COUNT_BITS = 16;
	localparam int NODE_BITS  = $clog2(NODE_COUNT);
	localparam int FREE_BITS  = NODE_BITS + 1;
	localparam int LEVEL_BITS = $clog2(KEY_BITS);

	localparam logic [1:0] FUNC_INSERT = 2'd0;
	localparam logic [1:0] FUNC_DELETE = 2'd1;
	localparam logic [1:0] FUNC_QUERY  = 2'd2;

	localparam logic [1:0] STAT_OK     = 2'd0;
	localparam logic [1:0] STAT_ABSENT = 2'd1;
	localparam logic [1:0] STAT_EMPTY  = 2'd2;
	localparam logic [1:0] STAT_FULL   = 2'd3;

	typedef struct packed {
		logic [1:0]          func;
		logic [KEY_BITS-1:0] key;
	} req_t;

	typedef struct packed {
		logic [KEY_BITS-1:0] partner;
		logic [1:0]          status;
	} rsp_t;

	// child pointers and the pass counts of those children
	typedef struct packed {
		logic [NODE_BITS-1:0]  child0;
		logic [NODE_BITS-1:0]  child1;
		logic [COUNT_BITS-1:0] count0;
		logic [COUNT_BITS-1:0] count1;
	} node_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_UPDATE,
		ST_QUERY,
		ST_DONE
	} state_t;

endpackage

FILE: sv/binary_trie_min_xor.sv
// Insert and query walk one trie level per cycle through the node memory read port. Delete
// first checks the path and then walks it again to update it, as does insert near a full
// pool; status-only beats (full, empty, unused code) go straight to the result. A held result stalls the next beat.
// No new beat is accepted until the last one has loaded its result.
// Reset (arst_n low): clears control, root node and key total and sets the free pointer to 1; node memory is
// not cleared, as nodes past the free pointer are never read and each is written whole.
module binary_trie_min_xor
	import btmx_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	state_t state_q, state_d;

	logic [1:0]            func_q;
	logic [KEY_BITS-1:0]   key_q;
	logic [KEY_BITS-1:0]   sh_q;
	logic [KEY_BITS-1:0]   partner_q;
	logic [1:0]            status_q;
	logic [LEVEL_BITS-1:0] level_q;
	logic [NODE_BITS-1:0]  cur_q;
	logic                  at_root_q;
	logic                  fresh_q;
	logic [FREE_BITS-1:0]  free_q;
	logic [COUNT_BITS-1:0] total_q;
	node_t                 root_q;
	node_t                 rdata_q;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	node_t mem [NODE_COUNT];

	node_t                 w, wnew;
	logic                  b, hit, alloc, last, take;
	logic [NODE_BITS-1:0]  c_b, c_o, c_new, q_next, c_walk;
	logic [COUNT_BITS-1:0] n_b;
	logic                  pool_short, pool_roomy, total_full, accept, rsp_free;

	logic       walk, fresh_walk, restart, node_we, set_status, total_upd, load_rsp;
	logic       part_shift;
	logic [1:0] status_d;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		w      = at_root_q ? root_q : (fresh_q ? '0 : rdata_q);
		b      = sh_q[KEY_BITS-1];
		c_b    = b ? w.child1 : w.child0;
		c_o    = b ? w.child0 : w.child1;
		n_b    = b ? w.count1 : w.count0;
		hit    = (c_b != '0) && (n_b != '0);
		alloc  = (func_q == FUNC_INSERT) && (c_b == '0);
		c_new  = alloc ? free_q[NODE_BITS-1:0] : c_b;
		take   = hit ? b : ~b;
		q_next = hit ? c_b : c_o;
		last   = (level_q == '0);
		wnew   = w;
		if (func_q == FUNC_INSERT) begin
			if (b) begin
				wnew.child1 = c_new;
				wnew.count1 = n_b + 1'b1;
			end else begin
				wnew.child0 = c_new;
				wnew.count0 = n_b + 1'b1;
			end
		end else begin
			if (b) begin
				wnew.count1 = n_b - 1'b1;
			end else begin
				wnew.count0 = n_b - 1'b1;
			end
		end
		pool_short = ((FREE_BITS+1)'(free_q) + (FREE_BITS+1)'(level_q) + (FREE_BITS+1)'(1))
			> (FREE_BITS+1)'(NODE_COUNT);
		pool_roomy = ((FREE_BITS+1)'(free_q) + (FREE_BITS+1)'(KEY_BITS))
			<= (FREE_BITS+1)'(NODE_COUNT);
		total_full = &total_q;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.func)
						FUNC_INSERT: begin
							if (total_full)
								state_d = ST_DONE;
							else if (pool_roomy)
								state_d = ST_UPDATE;
							else
								state_d = ST_CHECK;
						end
						FUNC_DELETE: state_d = ST_CHECK;
						FUNC_QUERY:  state_d = (total_q == '0) ? ST_DONE : ST_QUERY;
						default:     state_d = ST_DONE;
					endcase
				end
			end
			ST_CHECK: begin
				if (func_q == FUNC_DELETE) begin
					if (!hit)
						state_d = ST_DONE;
					else if (last)
						state_d = ST_UPDATE;
				end else begin
					if (c_b == '0)
						state_d = pool_short ? ST_DONE : ST_UPDATE;
					else if (last)
						state_d = ST_UPDATE;
				end
			end
			ST_UPDATE: if (last) state_d = ST_DONE;
			ST_QUERY:  if (last) state_d = ST_DONE;
			ST_DONE:   if (rsp_free) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// datapath controls
	always_comb begin
		walk       = 1'b0;
		fresh_walk = 1'b0;
		c_walk     = c_b;
		restart    = 1'b0;
		node_we    = 1'b0;
		set_status = 1'b0;
		status_d   = STAT_OK;
		total_upd  = 1'b0;
		load_rsp   = 1'b0;
		part_shift = 1'b0;
		case (state_q)
			ST_IDLE: begin
				set_status = accept;
				if (req.func == FUNC_INSERT && total_full)
					status_d = STAT_FULL;
				else if (req.func == FUNC_QUERY && total_q == '0)
					status_d = STAT_EMPTY;
			end
			ST_CHECK: begin
				if (func_q == FUNC_DELETE) begin
					if (!hit) begin
						set_status = 1'b1;
						status_d   = STAT_ABSENT;
					end else if (last) begin
						restart = 1'b1;
					end else begin
						walk = 1'b1;
					end
				end else begin
					if (c_b == '0) begin
						if (pool_short) begin
							set_status = 1'b1;
							status_d   = STAT_FULL;
						end else begin
							restart = 1'b1;
						end
					end else if (last) begin
						restart = 1'b1;
					end else begin
						walk = 1'b1;
					end
				end
			end
			ST_UPDATE: begin
				node_we    = 1'b1;
				c_walk     = c_new;
				fresh_walk = alloc;
				total_upd  = last;
				walk       = !last;
			end
			ST_QUERY: begin
				part_shift = 1'b1;
				c_walk     = q_next;
				walk       = !last;
			end
			ST_DONE:  load_rsp = rsp_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			at_root_q   <= 1'b1;
			fresh_q     <= 1'b0;
			free_q      <= FREE_BITS'(1);
			total_q     <= '0;
			root_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept || restart) begin
				at_root_q <= 1'b1;
				fresh_q   <= 1'b0;
			end else if (walk) begin
				at_root_q <= 1'b0;
				fresh_q   <= fresh_walk;
			end
			if (node_we && alloc)
				free_q <= free_q + 1'b1;
			if (node_we && at_root_q)
				root_q <= wnew;
			if (total_upd)
				total_q <= (func_q == FUNC_INSERT) ? total_q + 1'b1 : total_q - 1'b1;
			if (load_rsp)
				rsp_valid_q <= 1'b1;
			else if (rsp_ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q    <= req.func;
			key_q     <= req.key;
			sh_q      <= req.key;
			level_q   <= LEVEL_BITS'(KEY_BITS - 1);
			cur_q     <= '0;
			partner_q <= '0;
		end else if (restart) begin
			sh_q    <= key_q;
			level_q <= LEVEL_BITS'(KEY_BITS - 1);
			cur_q   <= '0;
		end else begin
			if (walk || part_shift) begin
				sh_q    <= {sh_q[KEY_BITS-2:0], 1'b0};
				level_q <= level_q - 1'b1;
			end
			if (walk)
				cur_q <= c_walk;
			if (part_shift)
				partner_q <= {partner_q[KEY_BITS-2:0], take};
		end
		if (set_status)
			status_q <= status_d;
		if (load_rsp) begin
			rsp_q.partner <= partner_q;
			rsp_q.status  <= status_q;
		end
	end

	always_ff @(posedge clk) begin
		if (node_we && !at_root_q)
			mem[cur_q] <= wnew;
		rdata_q <= mem[c_walk];
	end

	a_root_total: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |->
			(((COUNT_BITS+1)'(root_q.count0) + (COUNT_BITS+1)'(root_q.count1))
				== (COUNT_BITS+1)'(total_q)))
		else $error("root pass counts disagree with key total");

	a_query_path: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_QUERY) |-> (hit || c_o != '0))
		else $error("query walk reached a node with no live child");

	a_delete_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UPDATE && func_q == FUNC_DELETE) |-> (n_b != '0))
		else $error("delete lowers a zero pass count");

	a_pool_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(node_we && alloc) |=> ((FREE_BITS+1)'(free_q) <= (FREE_BITS+1)'(NODE_COUNT)))
		else $error("node pool overrun");

endmodule
